// File: design/jsu_pkg.sv
// Shared types and codes of the JSON string unescaper.
// Used by the decoder, the result buffer, the top level and the checker.
package jsu_pkg;

   localparam int BYTE_W    = 8;
   localparam int KIND_W    = 2;
   localparam int ERR_W     = 3;
   localparam int MAX_RES   = 4;
   localparam int COUNT_W   = $clog2(MAX_RES + 1);
   localparam int USER_W    = KIND_W + ERR_W;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

   // Error codes.
   localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
   localparam logic [ERR_W-1:0] ERR_NO_CLOSE  = 3'd1;
   localparam logic [ERR_W-1:0] ERR_CONTROL   = 3'd2;
   localparam logic [ERR_W-1:0] ERR_BAD_HEX   = 3'd3;
   localparam logic [ERR_W-1:0] ERR_SURROGATE = 3'd4;
   localparam logic [ERR_W-1:0] ERR_NO_OPEN   = 3'd5;

   // All results caused by one input byte; data[0] goes out first.
   typedef struct packed {
      logic [COUNT_W-1:0]              count;
      logic [MAX_RES-1:0][BYTE_W-1:0]  data;
      logic [KIND_W-1:0]               kind;
      logic [ERR_W-1:0]                err;
   } jsu_bundle_type;

endpackage

// File: design/json_string_unescape_utf8_unit.sv
// JSON string unescaper: input byte register, decoder, and result buffer.
// Each byte passes from the input register through the decoder into the result buffer.
// Throughput: one input byte per cycle while the result buffer can take it; a byte that
// gives n results holds the input side until the single result port of the buffer takes its last.
// Reset (synchronous, active high) returns the decoder to idle and empties
// both the input register and the result buffer.
module json_string_unescape_utf8_unit (
   input  logic                          clock,
   input  logic                          reset,
   // Input channel.
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [jsu_pkg::BYTE_W-1:0]    req_tdata,   // [7:0] in_byte
   // Result channel.
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [jsu_pkg::BYTE_W-1:0]    rsp_tdata,   // [7:0] out_byte
   output logic [jsu_pkg::USER_W-1:0]    rsp_tuser,   // [1:0] kind, [4:2] error_code
   output logic                          rsp_tlast    // last result of this input byte
);

   // The input register holds one byte until the result buffer can take
   // everything that byte produces. Bytes that produce no result (the opening
   // quote, a backslash, most hex digits) wait for the buffer too but leave it untouched.
   logic                          in_valid_ff, in_valid_in;
   logic [jsu_pkg::BYTE_W-1:0]    in_byte_ff, in_byte_in;
   logic                          advance;
   logic                          load_ok;
   logic                          req_take;
   jsu_pkg::jsu_bundle_type       bundle;

   assign advance    = in_valid_ff && load_ok;
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_byte_ff <= in_byte_in;
   end

   // The decoder state moves only when its byte is handed on.
   jsu_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .byte_in (in_byte_ff),
      .bundle  (bundle)
   );

   // A bundle with no results is consumed without touching the buffer.
   jsu_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && bundle.count != '0),
      .bundle     (bundle),
      .load_ok    (load_ok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: design/jsu_decode.sv
// Decoder state machine: escape, hex and surrogate tracking, UTF-8 encoding.
// Depends on jsu_pkg for the result bundle type and codes.
module jsu_decode (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [jsu_pkg::BYTE_W-1:0]  byte_in,
   output jsu_pkg::jsu_bundle_type     bundle
);

   typedef enum logic [2:0] {
      M_IDLE    = 3'd0,
      M_STR     = 3'd1,
      M_ESC     = 3'd2,
      M_HEX     = 3'd3,
      M_WANT_BS = 3'd4,
      M_WANT_U  = 3'd5
   } mode_type;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5c;
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_N     = 8'h6e;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_U     = 8'h75;

   mode_type    mode_ff, mode_in;
   logic [1:0]  hex_count_ff, hex_count_in;
   logic [11:0] code_unit_ff, code_unit_in;
   logic        high_pending_ff, high_pending_in;
   logic [9:0]  high_bits_ff, high_bits_in;

   logic        hex_ok;
   logic [3:0]  hex_val;
   logic [15:0] unit;
   logic [10:0] plane;

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (byte_in inside {[8'h30:8'h39]}) begin
         hex_val = byte_in[3:0];
      end else if (byte_in inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
         hex_val = byte_in[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign unit  = {code_unit_ff, hex_val};
   assign plane = {1'b0, high_bits_ff} + 11'h040;

   always_comb begin
      mode_in         = mode_ff;
      hex_count_in    = hex_count_ff;
      code_unit_in    = code_unit_ff;
      high_pending_in = high_pending_ff;
      high_bits_in    = high_bits_ff;
      bundle          = '0;
      bundle.kind     = jsu_pkg::KIND_DATA;
      bundle.err      = jsu_pkg::ERR_NONE;

      case (mode_ff)
         M_STR: begin
            if (byte_in == CH_QUOTE) begin
               mode_in      = M_IDLE;
               bundle.count = 3'd1;
               bundle.kind  = jsu_pkg::KIND_END;
            end else if (byte_in == CH_NUL) begin
               bundle.count = 3'd1;
               bundle.kind  = jsu_pkg::KIND_ERROR;
               bundle.err   = jsu_pkg::ERR_NO_CLOSE;
            end else if (byte_in == CH_BSL) begin
               mode_in = M_ESC;
            end else if (byte_in < 8'h20) begin
               bundle.count = 3'd1;
               bundle.kind  = jsu_pkg::KIND_ERROR;
               bundle.err   = jsu_pkg::ERR_CONTROL;
            end else begin
               bundle.count   = 3'd1;
               bundle.data[0] = byte_in;
            end
         end
         M_ESC: begin
            mode_in        = M_STR;
            bundle.count   = 3'd1;
            bundle.data[0] = byte_in;
            case (byte_in)
               CH_NUL: begin
                  bundle.data[0] = 8'h00;
                  bundle.kind    = jsu_pkg::KIND_ERROR;
                  bundle.err     = jsu_pkg::ERR_NO_CLOSE;
               end
               CH_QUOTE, CH_BSL, CH_SLASH: ;
               CH_B: bundle.data[0] = 8'h08;
               CH_T: bundle.data[0] = 8'h09;
               CH_F: bundle.data[0] = 8'h0c;
               CH_N: bundle.data[0] = 8'h0a;
               CH_R: bundle.data[0] = 8'h0d;
               CH_U: begin
                  mode_in      = M_HEX;
                  hex_count_in = 2'd0;
                  code_unit_in = '0;
                  bundle       = '0;
               end
               default: bundle = '0;   // unknown letters are dropped
            endcase
         end
         M_HEX: begin
            if (!hex_ok) begin
               bundle.count = 3'd1;
               bundle.kind  = jsu_pkg::KIND_ERROR;
               bundle.err   = jsu_pkg::ERR_BAD_HEX;
            end else if (hex_count_ff != 2'd3) begin
               hex_count_in = hex_count_ff + 2'd1;
               code_unit_in = unit[11:0];
            end else begin
               hex_count_in = 2'd0;
               code_unit_in = '0;
               if (high_pending_ff) begin
                  if (unit[15:10] != 6'b110111) begin
                     bundle.count = 3'd1;
                     bundle.kind  = jsu_pkg::KIND_ERROR;
                     bundle.err   = jsu_pkg::ERR_SURROGATE;
                  end else begin
                     // Surrogate pair: code point {plane, low bits} is above 0xffff.
                     mode_in         = M_STR;
                     high_pending_in = 1'b0;
                     high_bits_in    = '0;
                     bundle.count    = 3'd4;
                     bundle.data[0]  = {5'b11110, plane[10:8]};
                     bundle.data[1]  = {2'b10, plane[7:2]};
                     bundle.data[2]  = {2'b10, plane[1:0], unit[9:6]};
                     bundle.data[3]  = {2'b10, unit[5:0]};
                  end
               end else if (unit[15:10] == 6'b110110) begin
                  mode_in         = M_WANT_BS;
                  high_pending_in = 1'b1;
                  high_bits_in    = unit[9:0];
               end else begin
                  mode_in = M_STR;
                  if (unit < 16'h0080) begin
                     bundle.count   = 3'd1;
                     bundle.data[0] = unit[7:0];
                  end else if (unit < 16'h0800) begin
                     bundle.count   = 3'd2;
                     bundle.data[0] = {3'b110, unit[10:6]};
                     bundle.data[1] = {2'b10, unit[5:0]};
                  end else begin
                     bundle.count   = 3'd3;
                     bundle.data[0] = {4'b1110, unit[15:12]};
                     bundle.data[1] = {2'b10, unit[11:6]};
                     bundle.data[2] = {2'b10, unit[5:0]};
                  end
               end
            end
         end
         M_WANT_BS: begin
            if (byte_in == CH_BSL) begin
               mode_in = M_WANT_U;
            end else begin
               bundle.count = 3'd1;
               bundle.kind  = jsu_pkg::KIND_ERROR;
               bundle.err   = jsu_pkg::ERR_SURROGATE;
            end
         end
         M_WANT_U: begin
            if (byte_in == CH_U) begin
               mode_in      = M_HEX;
               hex_count_in = 2'd0;
               code_unit_in = '0;
            end else begin
               bundle.count = 3'd1;
               bundle.kind  = jsu_pkg::KIND_ERROR;
               bundle.err   = jsu_pkg::ERR_SURROGATE;
            end
         end
         default: begin
            if (byte_in == CH_QUOTE) begin
               mode_in         = M_STR;
               hex_count_in    = 2'd0;
               code_unit_in    = '0;
               high_pending_in = 1'b0;
               high_bits_in    = '0;
            end else begin
               bundle.count = 3'd1;
               bundle.kind  = jsu_pkg::KIND_ERROR;
               bundle.err   = jsu_pkg::ERR_NO_OPEN;
            end
         end
      endcase

      // Every error drops back to idle with all tracking cleared.
      if (bundle.kind == jsu_pkg::KIND_ERROR) begin
         mode_in         = M_IDLE;
         hex_count_in    = 2'd0;
         code_unit_in    = '0;
         high_pending_in = 1'b0;
         high_bits_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= M_IDLE;
         hex_count_ff    <= 2'd0;
         code_unit_ff    <= '0;
         high_pending_ff <= 1'b0;
         high_bits_ff    <= '0;
      end else if (step) begin
         mode_ff         <= mode_in;
         hex_count_ff    <= hex_count_in;
         code_unit_ff    <= code_unit_in;
         high_pending_ff <= high_pending_in;
         high_bits_ff    <= high_bits_in;
      end
   end

endmodule

// File: design/jsu_emit.sv
// Result buffer: holds the results of one input byte and sends them one per cycle while rsp_tready is high.
// Depends on jsu_pkg for the result bundle type.
module jsu_emit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  jsu_pkg::jsu_bundle_type       bundle,
   output logic                          load_ok,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [jsu_pkg::BYTE_W-1:0]    rsp_tdata,
   output logic [jsu_pkg::USER_W-1:0]    rsp_tuser,
   output logic                          rsp_tlast
);

   logic [jsu_pkg::MAX_RES-1:0][jsu_pkg::BYTE_W-1:0] data_ff, data_in;
   logic [jsu_pkg::KIND_W-1:0]  kind_ff, kind_in;
   logic [jsu_pkg::ERR_W-1:0]   err_ff, err_in;
   logic [jsu_pkg::COUNT_W-1:0] rem_ff, rem_in;
   logic                        take;

   assign rsp_tvalid = (rem_ff != '0);
   assign take       = rsp_tvalid && rsp_tready;
   assign load_ok    = !rsp_tvalid || (take && rem_ff == 3'd1);
   assign rsp_tdata  = data_ff[0];
   assign rsp_tuser  = {err_ff, kind_ff};
   assign rsp_tlast  = (rem_ff == 3'd1);

   always_comb begin
      data_in = data_ff;
      kind_in = kind_ff;
      err_in  = err_ff;
      rem_in  = rem_ff;
      if (load) begin
         data_in = bundle.data;
         kind_in = bundle.kind;
         err_in  = bundle.err;
         rem_in  = bundle.count;
      end else if (take) begin
         data_in = {8'h00, data_ff[jsu_pkg::MAX_RES-1:1]};
         rem_in  = rem_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
      data_ff <= data_in;
      kind_ff <= kind_in;
      err_ff  <= err_in;
   end

endmodule

// File: design/jsu_checker.sv
// Port-level checks of the JSON string unescaper, bound to the top level.
// Depends on jsu_pkg for result kinds and error codes.
module jsu_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [jsu_pkg::BYTE_W-1:0]    rsp_tdata,
   input logic [jsu_pkg::USER_W-1:0]    rsp_tuser,
   input logic                          rsp_tlast
);

   // A stalled result transaction keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // Data results carry no error code.
   a_data_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == jsu_pkg::KIND_DATA |->
         rsp_tuser[4:2] == jsu_pkg::ERR_NONE)
      else $error("data result with error code");

   // End and error results are single, zero-data, and closing.
   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[1:0] == jsu_pkg::KIND_END ||
                     rsp_tuser[1:0] == jsu_pkg::KIND_ERROR) |->
         rsp_tlast && rsp_tdata == 8'h00)
      else $error("marker result malformed");

   // An error result always names a cause.
   a_error_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == jsu_pkg::KIND_ERROR |->
         rsp_tuser[4:2] != jsu_pkg::ERR_NONE)
      else $error("error result without a code");

   // Right after reset no result is presented and the input side is ready.
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid && req_tready)
      else $error("block not empty after reset");

endmodule

bind json_string_unescape_utf8_unit jsu_checker u_jsu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// File: tb/json_string_unescape_utf8_checker.sv
`timescale 1ns / 1ps
// Checker for the JSON string unescaper: decodes every accepted input byte on
// its own and compares the block's results, in order, field by field.
// Depends on jsu_pkg for the field widths, result kinds and error codes.
module json_string_unescape_utf8_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [jsu_pkg::BYTE_W-1:0]    req_tdata,   // [7:0] in_byte
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [jsu_pkg::BYTE_W-1:0]    rsp_tdata,   // [7:0] out_byte
   input  logic [jsu_pkg::USER_W-1:0]    rsp_tuser,   // [1:0] kind, [4:2] error_code
   input  logic                          rsp_tlast,
   output int                            fail_count,
   output int                            outstanding
);

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_SLASH  = 8'h2f;
   localparam logic [7:0] CH_U      = 8'h75;

   typedef enum logic [2:0] {
      SCAN_IDLE, SCAN_STRING, SCAN_ESCAPE, SCAN_HEX, SCAN_WANT_BSLASH, SCAN_WANT_U
   } scan_state_type;

   typedef struct packed {
      logic [jsu_pkg::BYTE_W-1:0] data;
      logic [jsu_pkg::KIND_W-1:0] kind;
      logic [jsu_pkg::ERR_W-1:0]  err;
      logic                       last;
   } unescaped_item_type;

   scan_state_type       scan_state;
   logic [1:0]           digits_seen;
   logic [15:0]          unit_acc;
   logic                 surrogate_wait;
   logic [9:0]           surrogate_hi;
   unescaped_item_type   unescaped_q[$];

   function automatic void emit(input logic [7:0] b,
                                input logic [jsu_pkg::KIND_W-1:0] k,
                                input logic [jsu_pkg::ERR_W-1:0] e);
      unescaped_item_type r;
      r.data = b;
      r.kind = k;
      r.err  = e;
      r.last = 1'b0;
      unescaped_q.insert(unescaped_q.size(), r);
   endfunction

   // Any error drops the string and everything gathered for a \u escape.
   function automatic void abort_string(input logic [jsu_pkg::ERR_W-1:0] e);
      scan_state     = SCAN_IDLE;
      digits_seen    = '0;
      unit_acc       = '0;
      surrogate_wait = 1'b0;
      surrogate_hi   = '0;
      emit(8'h00, jsu_pkg::KIND_ERROR, e);
   endfunction

   function automatic void utf8_encode(input logic [20:0] cp);
      if (cp < 21'h80) begin
         emit(cp[7:0], jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
      end else if (cp < 21'h800) begin
         emit({3'b110, cp[10:6]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
         emit({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
      end else if (cp < 21'h10000) begin
         emit({4'b1110, cp[15:12]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
         emit({2'b10, cp[11:6]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
         emit({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
      end else begin
         emit({5'b11110, cp[20:18]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
         emit({2'b10, cp[17:12]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
         emit({2'b10, cp[11:6]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
         emit({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
      end
   endfunction

   function automatic int hex_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
   endfunction

   // Called once the fourth hex digit is in.
   function automatic void close_unit();
      logic [15:0] u;
      logic [20:0] cp;
      u           = unit_acc;
      digits_seen = '0;
      unit_acc    = '0;
      if (surrogate_wait) begin
         if (u < 16'hdc00 || u >= 16'he000) begin
            abort_string(jsu_pkg::ERR_SURROGATE);
            return;
         end
         cp = (({11'd0, surrogate_hi} + 21'h40) << 10) | {5'd0, u - 16'hdc00};
         surrogate_wait = 1'b0;
         surrogate_hi   = '0;
         scan_state     = SCAN_STRING;
         utf8_encode(cp);
      end else if (u >= 16'hd800 && u < 16'hdc00) begin
         surrogate_wait = 1'b1;
         surrogate_hi   = u[9:0];
         scan_state     = SCAN_WANT_BSLASH;
      end else begin
         scan_state = SCAN_STRING;
         utf8_encode({5'd0, u});
      end
   endfunction

   function automatic void unescape_byte(input logic [7:0] c);
      int                 h;
      int                 before_n;
      unescaped_item_type r;
      before_n = unescaped_q.size();
      case (scan_state)
         SCAN_STRING: begin
            if (c == CH_QUOTE) begin
               scan_state = SCAN_IDLE;
               emit(8'h00, jsu_pkg::KIND_END, jsu_pkg::ERR_NONE);
            end else if (c == 8'h00) begin
               abort_string(jsu_pkg::ERR_NO_CLOSE);
            end else if (c == CH_BSLASH) begin
               scan_state = SCAN_ESCAPE;
            end else if (c < 8'h20) begin
               abort_string(jsu_pkg::ERR_CONTROL);
            end else begin
               emit(c, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            end
         end
         SCAN_ESCAPE: begin
            case (c)
               8'h00: abort_string(jsu_pkg::ERR_NO_CLOSE);
               CH_QUOTE, CH_BSLASH, CH_SLASH: begin
                  scan_state = SCAN_STRING;
                  emit(c, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
               end
               "b": begin
                  scan_state = SCAN_STRING;
                  emit(8'h08, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
               end
               "t": begin
                  scan_state = SCAN_STRING;
                  emit(8'h09, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
               end
               "f": begin
                  scan_state = SCAN_STRING;
                  emit(8'h0c, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
               end
               "n": begin
                  scan_state = SCAN_STRING;
                  emit(8'h0a, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
               end
               "r": begin
                  scan_state = SCAN_STRING;
                  emit(8'h0d, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
               end
               CH_U: begin
                  scan_state  = SCAN_HEX;
                  digits_seen = '0;
                  unit_acc    = '0;
               end
               default: scan_state = SCAN_STRING;
            endcase
         end
         SCAN_HEX: begin
            h = hex_value(c);
            if (h < 0) begin
               abort_string(jsu_pkg::ERR_BAD_HEX);
            end else begin
               unit_acc = {unit_acc[11:0], 4'(h)};
               if (digits_seen == 2'd3) close_unit();
               else digits_seen = digits_seen + 2'd1;
            end
         end
         SCAN_WANT_BSLASH: begin
            if (c == CH_BSLASH) scan_state = SCAN_WANT_U;
            else abort_string(jsu_pkg::ERR_SURROGATE);
         end
         SCAN_WANT_U: begin
            if (c == CH_U) begin
               scan_state  = SCAN_HEX;
               digits_seen = '0;
               unit_acc    = '0;
            end else begin
               abort_string(jsu_pkg::ERR_SURROGATE);
            end
         end
         default: begin
            if (c == CH_QUOTE) begin
               scan_state     = SCAN_STRING;
               digits_seen    = '0;
               unit_acc       = '0;
               surrogate_wait = 1'b0;
               surrogate_hi   = '0;
            end else begin
               abort_string(jsu_pkg::ERR_NO_OPEN);
            end
         end
      endcase
      if (unescaped_q.size() > before_n) begin
         r      = unescaped_q[unescaped_q.size() - 1];
         r.last = 1'b1;
         unescaped_q[unescaped_q.size() - 1] = r;
      end
   endfunction

   always @(posedge clock) begin
      unescaped_item_type want;
      if (reset) begin
         scan_state     = SCAN_IDLE;
         digits_seen    = '0;
         unit_acc       = '0;
         surrogate_wait = 1'b0;
         surrogate_hi   = '0;
         fail_count     = 0;
         unescaped_q.delete();
      end else begin
         if (req_tvalid && req_tready) unescape_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (unescaped_q.size() == 0) begin
               $error("unexpected result: out_byte 0x%02h kind %0d error_code %0d last %0d",
                      rsp_tdata, rsp_tuser[1:0], rsp_tuser[4:2], rsp_tlast);
               fail_count++;
            end else begin
               want = unescaped_q.pop_front();
               if (rsp_tdata !== want.data) begin
                  $error("out_byte: expected 0x%02h, actual 0x%02h", want.data, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tuser[1:0] !== want.kind) begin
                  $error("kind: expected %0d, actual %0d", want.kind, rsp_tuser[1:0]);
                  fail_count++;
               end
               if (rsp_tuser[4:2] !== want.err) begin
                  $error("error_code: expected %0d, actual %0d", want.err, rsp_tuser[4:2]);
                  fail_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last: expected %0d, actual %0d", want.last, rsp_tlast);
                  fail_count++;
               end
            end
         end
      end
      outstanding = unescaped_q.size();
   end

endmodule

// File: tb/tb_json_string_unescape_utf8_unit.sv
`timescale 1ns / 1ps
// Top of the JSON string unescaper testbench: builds the byte stream, drives
// it with bursts and gaps, stalls the result side, and gives the verdict.
// Depends on jsu_pkg, the unescaper and json_string_unescape_utf8_checker.
module tb_json_string_unescape_utf8_unit;

   // The run limit lies far beyond the slowest correct run.
   localparam int CLOCK_LIMIT = 200000;
   // Bytes sent in all, the directed opening included; the last string may
   // run a little past this.
   localparam int TEXT_BYTES  = 210;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_SLASH  = 8'h2f;
   localparam logic [7:0] CH_U      = 8'h75;

   // Every input of the block has a known value from time zero.
   logic                        clock      = 1'b0;
   logic                        reset      = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic [jsu_pkg::BYTE_W-1:0]  req_tdata  = '0;
   logic                        rsp_tready = 1'b0;

   logic                        req_tready;
   logic                        rsp_tvalid;
   logic [jsu_pkg::BYTE_W-1:0]  rsp_tdata;
   logic [jsu_pkg::USER_W-1:0]  rsp_tuser;
   logic                        rsp_tlast;

   int                          fail_count;
   int                          outstanding;
   int                          cycle_count = 0;

   // Raw text bytes, in the order they are sent.
   logic [7:0]                  text_q[$];

   always #5 clock = ~clock;

   json_string_unescape_utf8_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   json_string_unescape_utf8_checker unescape_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // Appends one byte to the text.
   function automatic void add_byte(input logic [7:0] c);
      text_q.insert(text_q.size(), c);
   endfunction

   // A hex digit for one nibble; letters come in either case at random.
   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      if (nib < 4'd10) return 8'h30 + 8'(nib);
      if ($urandom_range(0, 1) == 0) return 8'h61 + 8'(nib - 4'd10);
      return 8'h41 + 8'(nib - 4'd10);
   endfunction

   function automatic bit is_hex(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   // Letters that have a meaning after a backslash, zero aside.
   function automatic bit is_escape_letter(input logic [7:0] c);
      case (c)
         CH_QUOTE, CH_BSLASH, CH_SLASH, "b", "t", "f", "n", "r", CH_U: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic [7:0] escape_letter(input int idx);
      case (idx)
         0: return CH_QUOTE;
         1: return CH_BSLASH;
         2: return CH_SLASH;
         3: return "b";
         4: return "t";
         5: return "f";
         6: return "n";
         default: return "r";
      endcase
   endfunction

   // ASCII from 0x20 to 0x7f that stands for itself inside a string.
   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      do c = 8'($urandom_range(8'h20, 8'h7f)); while (c == CH_QUOTE || c == CH_BSLASH);
      return c;
   endfunction

   function automatic void push_unit(input logic [15:0] u);
      add_byte(CH_BSLASH);
      add_byte(CH_U);
      for (int k = 3; k >= 0; k--) add_byte(hex_digit(u[k*4 +: 4]));
   endfunction

   // A code unit that stands on its own: one, two or three UTF-8 bytes,
   // lone low surrogates and both ends of the range included.
   function automatic logic [15:0] pick_unit();
      case ($urandom_range(0, 5))
         0: return 16'($urandom_range(0, 16'h7f));
         1: return 16'($urandom_range(16'h80, 16'h7ff));
         2: return 16'($urandom_range(16'h800, 16'hd7ff));
         3: return 16'($urandom_range(16'hdc00, 16'hdfff));
         4: return 16'($urandom_range(16'he000, 16'hffff));
         default: return ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hffff;
      endcase
   endfunction

   function automatic logic [15:0] pick_high();
      return 16'($urandom_range(16'hd800, 16'hdbff));
   endfunction

   // One piece of well-formed string content.
   function automatic void push_token();
      logic [7:0] c;
      case ($urandom_range(0, 6))
         0, 1: add_byte(plain_char());
         2: add_byte(8'($urandom_range(8'h80, 8'hff)));
         3: begin
            add_byte(CH_BSLASH);
            add_byte(escape_letter($urandom_range(0, 7)));
         end
         4: begin
            // Unknown escape, control bytes and high bytes among them.
            do c = 8'($urandom_range(1, 255)); while (is_escape_letter(c));
            add_byte(CH_BSLASH);
            add_byte(c);
         end
         5: push_unit(pick_unit());
         default: begin
            push_unit(pick_high());
            push_unit(16'($urandom_range(16'hdc00, 16'hdfff)));
         end
      endcase
   endfunction

   function automatic void push_well_formed();
      add_byte(CH_QUOTE);
      repeat ($urandom_range(0, 8)) push_token();
      add_byte(CH_QUOTE);
   endfunction

   // A string that ends in an error, or a stray byte outside any string.
   function automatic void push_broken();
      logic [7:0]  c;
      logic [15:0] u;
      if ($urandom_range(0, 7) == 0) begin
         do c = 8'($urandom()); while (c == CH_QUOTE);
         add_byte(c);
         return;
      end
      add_byte(CH_QUOTE);
      repeat ($urandom_range(0, 3)) push_token();
      case ($urandom_range(0, 6))
         0: add_byte(8'h00);
         1: add_byte(8'($urandom_range(1, 8'h1f)));
         2: begin
            add_byte(CH_BSLASH);
            add_byte(8'h00);
         end
         3: begin
            // The bad digit may fall anywhere among the four.
            add_byte(CH_BSLASH);
            add_byte(CH_U);
            repeat ($urandom_range(0, 3)) add_byte(hex_digit(4'($urandom())));
            do c = 8'($urandom()); while (is_hex(c));
            add_byte(c);
         end
         4: begin
            push_unit(pick_high());
            if ($urandom_range(0, 3) == 0) c = 8'h00;
            else do c = 8'($urandom()); while (c == CH_BSLASH);
            add_byte(c);
         end
         5: begin
            push_unit(pick_high());
            add_byte(CH_BSLASH);
            if ($urandom_range(0, 3) == 0) c = 8'h00;
            else do c = 8'($urandom()); while (c == CH_U);
            add_byte(c);
         end
         default: begin
            // High surrogate followed by a unit that is not a low half.
            push_unit(pick_high());
            case ($urandom_range(0, 2))
               0: u = 16'hdbff;
               1: u = 16'he000;
               default: do u = 16'($urandom()); while (u >= 16'hdc00 && u < 16'he000);
            endcase
            push_unit(u);
         end
      endcase
   endfunction

   function automatic void build_stimulus();
      // Directed opening: a zero byte while idle, raw 0xff, the largest
      // surrogate pair, a zero code unit, then a control byte and a zero
      // byte inside strings.
      add_byte(8'h00);
      add_byte(CH_QUOTE);
      add_byte(8'hff);
      push_unit(16'hdbff);
      push_unit(16'hdfff);
      push_unit(16'h0000);
      add_byte(CH_QUOTE);
      add_byte(CH_QUOTE);
      add_byte(8'h1f);
      add_byte(CH_QUOTE);
      add_byte(8'h00);
      // Mostly well-formed strings, so the escape and surrogate states are
      // reached often; the rest are broken strings and stray bytes.
      while (text_q.size() < TEXT_BYTES) begin
         if ($urandom_range(0, 3) == 0) push_broken();
         else push_well_formed();
      end
   endfunction

   // Watchdog: a hung handshake or a result that never comes ends the run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CLOCK_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Result side: a stall style is chosen at random for a stretch of cycles.
   // Style 0 never stalls, 1 stalls half the time, 2 rarely, 3 takes one
   // transaction in three, which holds multi-byte runs for longest.
   int ready_style = 0;
   int style_left  = 0;
   always @(negedge clock) begin
      if (style_left == 0) begin
         ready_style = $urandom_range(0, 3);
         style_left  = $urandom_range(16, 96);
      end else begin
         style_left--;
      end
      case (ready_style)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 1) == 0);
         2: rsp_tready <= ($urandom_range(0, 7) != 0);
         default: rsp_tready <= (style_left % 3 == 0);
      endcase
   end

   // Input side: bytes go out in bursts, mostly short, sometimes long enough
   // to keep the block busy without a break, with random gaps in between.
   initial begin
      int burst_left;
      int gap;
      build_stimulus();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      burst_left = 0;
      foreach (text_q[i]) begin
         if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 10);
            gap = $urandom_range(0, 4);
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         req_tvalid <= 1'b1;
         req_tdata  <= text_q[i];
         // The transaction completes at the first edge with tready high.
         do @(posedge clock); while (!req_tready);
         @(negedge clock);
         burst_left--;
      end
      req_tvalid <= 1'b0;

      // Drain, then keep the clock running so that any stray result still shows.
      while (outstanding != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
